// ----- rtl/core/sit_pkg.sv -----
// Shared types and constants for the tolerant segment intersection core.
package sit_pkg;

  localparam int CRD_W     = 36;
  localparam int DIF_W     = 37;
  localparam int MAG_W     = 36;
  localparam int HLF_W     = 18;
  localparam int PRD_W     = 72;
  localparam int WIDE_W    = 74;
  localparam int DET_W     = 73;
  localparam int TOL_W     = 16;
  localparam int PAR_W     = 17;
  localparam int CRD_FRAC  = 8;
  localparam int PAR_FRAC  = 16;
  localparam int ROOT_W    = 37;
  localparam int SREM_W    = 39;
  localparam int SQ_STEPS  = 37;
  localparam int DV_STEPS  = 26;
  localparam int MQ_STEPS  = 24;
  localparam int MQ_W      = 24;
  localparam int BIG_SH    = DV_STEPS - PAR_FRAC - 1;
  localparam int N_IT      = SQ_STEPS + MQ_STEPS;
  localparam int N_PROD    = 8;
  localparam int IN_DATA_W  = 8 * CRD_W;
  localparam int OUT_DATA_W = 112;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd256;

  typedef enum logic [1:0] {
    ST_CROSS    = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CRD_W-1:0]  ax;
    logic signed [CRD_W-1:0]  ay;
    logic signed [DIF_W-1:0]  dx1;
    logic signed [DIF_W-1:0]  dy1;
    logic                     par;
    logic                     tneg;
    logic                     tzero;
    logic                     tbig;
    logic                     uneg;
    logic                     uzero;
    logic                     ubig;
    logic [DET_W-1:0]         det;
    logic [DET_W-1:0]         tr;
    logic [DET_W-1:0]         ur;
    logic [DV_STEPS-1:0]      tbits;
    logic [DV_STEPS-1:0]      ubits;
    logic [DV_STEPS-1:0]      tq2;
    logic [DV_STEPS-1:0]      uq2;
    logic [WIDE_W-1:0]        s;
    logic [ROOT_W-1:0]        root;
    logic [SREM_W-1:0]        srem;
    logic [ROOT_W-1:0]        mr;
    logic [MQ_W-1:0]          mbits;
    logic [MQ_W-1:0]          mq;
  } it_t;

endpackage

// ----- rtl/core/segment_intersection_tolerant_core.sv -----
// Tolerant segment intersection core: Cramer solve, root, margin divide and bound check.
//
//  channel   | dir | handshake              | payload
//  s_axis    | in  | s_axis_tvalid/tready   | tdata: a_x,a_y,b_x,b_y,c_x,c_y,d_x,d_y
//  m_axis    | out | m_axis_tvalid/tready   | tuser: status; tdata: t,u,cross_x,cross_y
//  cfg       | in  | cfg_we_i               | cfg_wdata_i: tolerance
//
// One request per cycle while the output register is empty or taken.
// Depth is set by the 37-step square root followed by the 24-step margin divider.
// All stages advance together whenever the output register is empty or taken.
// Reset clears valid bits and loads tolerance with one meter.
module segment_intersection_tolerant_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
  input  logic [sit_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // param_first, param_second, cross_x, cross_y, zero fill
  output logic [sit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]                     m_axis_tuser,
  input  logic                           cfg_we_i,
  input  logic [sit_pkg::TOL_W-1:0]      cfg_wdata_i
);
  import sit_pkg::*;

  function automatic logic [MAG_W-1:0] mag_of(logic signed [DIF_W-1:0] v);
    logic [DIF_W-1:0] m;
    m = v[DIF_W-1] ? DIF_W'(-v) : DIF_W'(v);
    return m[MAG_W-1:0];
  endfunction

  function automatic it_t it_step(it_t x, int k);
    it_t              y;
    logic [SREM_W+1:0] scur;
    logic [SREM_W+1:0] strial;
    logic [DET_W:0]    dcur;
    logic [ROOT_W-1:0] den;
    logic [ROOT_W:0]   mcur;
    y = x;
    if (k < SQ_STEPS) begin
      scur   = {x.srem, x.s[WIDE_W-1 -: 2]};
      strial = {2'b00, x.root, 2'b01};
      if (scur >= strial) begin
        y.srem = SREM_W'(scur - strial);
        y.root = {x.root[ROOT_W-2:0], 1'b1};
      end else begin
        y.srem = scur[SREM_W-1:0];
        y.root = {x.root[ROOT_W-2:0], 1'b0};
      end
      y.s = {x.s[WIDE_W-3:0], 2'b00};
    end
    if (k < DV_STEPS) begin
      dcur = {x.tr, x.tbits[DV_STEPS-1]};
      if (dcur >= {1'b0, x.det}) begin
        y.tr  = DET_W'(dcur - {1'b0, x.det});
        y.tq2 = {x.tq2[DV_STEPS-2:0], 1'b1};
      end else begin
        y.tr  = dcur[DET_W-1:0];
        y.tq2 = {x.tq2[DV_STEPS-2:0], 1'b0};
      end
      y.tbits = {x.tbits[DV_STEPS-2:0], 1'b0};
      dcur = {x.ur, x.ubits[DV_STEPS-1]};
      if (dcur >= {1'b0, x.det}) begin
        y.ur  = DET_W'(dcur - {1'b0, x.det});
        y.uq2 = {x.uq2[DV_STEPS-2:0], 1'b1};
      end else begin
        y.ur  = dcur[DET_W-1:0];
        y.uq2 = {x.uq2[DV_STEPS-2:0], 1'b0};
      end
      y.ubits = {x.ubits[DV_STEPS-2:0], 1'b0};
    end
    if (k >= SQ_STEPS) begin
      den  = (x.root < ROOT_W'(1 << CRD_FRAC)) ? ROOT_W'(1 << CRD_FRAC) : x.root;
      mcur = {x.mr, x.mbits[MQ_W-1]};
      if (mcur >= {1'b0, den}) begin
        y.mr = ROOT_W'(mcur - {1'b0, den});
        y.mq = {x.mq[MQ_W-2:0], 1'b1};
      end else begin
        y.mr = mcur[ROOT_W-1:0];
        y.mq = {x.mq[MQ_W-2:0], 1'b0};
      end
      y.mbits = {x.mbits[MQ_W-2:0], 1'b0};
    end
    return y;
  endfunction

  logic en;
  logic [TOL_W-1:0] tol_q;

  // stage 1: differences
  logic v1_q;
  logic signed [CRD_W-1:0] ax1_q, ay1_q;
  logic signed [DIF_W-1:0] dx1_q, dy1_q, dx2_q, dy2_q, ex_q, ey_q;
  logic [TOL_W-1:0] tol1_q;
  logic signed [CRD_W-1:0] in_f [8];

  // stage 2: partial products
  logic v2_q;
  logic [HLF_W*2-1:0] pp_q [N_PROD][4];
  logic               ps_q [N_PROD];
  logic [2*TOL_W-1:0] eps2_q;
  logic signed [CRD_W-1:0] ax2_q, ay2_q;
  logic signed [DIF_W-1:0] dx1b_q, dy1b_q;
  logic [TOL_W-1:0] tol2_q;
  logic signed [DIF_W-1:0] opa [N_PROD];
  logic signed [DIF_W-1:0] opb [N_PROD];
  logic [MAG_W-1:0] ma [N_PROD];
  logic [MAG_W-1:0] mb [N_PROD];

  // stage 3: signed products
  logic v3_q;
  logic signed [WIDE_W-1:0] pr_q [N_PROD];
  logic [2*TOL_W-1:0] eps3_q;
  logic signed [CRD_W-1:0] ax3_q, ay3_q;
  logic signed [DIF_W-1:0] dx1c_q, dy1c_q;
  logic [TOL_W-1:0] tol3_q;

  // stage 4: determinant and numerators
  logic v4_q;
  logic signed [WIDE_W-1:0] det4_q, tn4_q, un4_q;
  logic [WIDE_W-1:0] s4_q;
  logic [2*TOL_W-1:0] eps4_q;
  logic signed [CRD_W-1:0] ax4_q, ay4_q;
  logic signed [DIF_W-1:0] dx1d_q, dy1d_q;
  logic [TOL_W-1:0] tol4_q;

  // stage 5: magnitudes and signs
  logic v5_q;
  logic [DET_W-1:0] adet5_q, tm5_q, um5_q;
  logic tneg5_q, uneg5_q, tz5_q, uz5_q, par5_q;
  logic [WIDE_W-1:0] s5_q;
  logic signed [CRD_W-1:0] ax5_q, ay5_q;
  logic signed [DIF_W-1:0] dx1e_q, dy1e_q;
  logic [TOL_W-1:0] tol5_q;
  logic [DET_W-1:0] adet5_d, tm5_d, um5_d;
  logic dneg5;

  // iterative stages
  it_t  it_q [N_IT+1];
  logic itv_q [N_IT+1];
  it_t  it0_d;

  // final stages
  logic v7_q;
  status_e st7_q;
  logic [PAR_W-1:0] tq7_q, uq7_q;
  logic signed [CRD_W-1:0] ax7_q, ay7_q;
  logic signed [DIF_W-1:0] dx7_q, dy7_q;
  logic [MQ_W:0] tqf, uqf, lo_lim, hi_lim;
  logic tex, uex, tok, uok;
  logic [PAR_W-1:0] tcl, ucl;
  status_e st7_d;

  logic v8_q;
  status_e st8_q;
  logic [PAR_W-1:0] tq8_q, uq8_q;
  logic signed [CRD_W-1:0] ax8_q, ay8_q;
  logic signed [DIF_W+PAR_W:0] px8_q, py8_q;

  logic out_v_q;
  status_e st_out_q;
  logic [PAR_W-1:0] tq_out_q, uq_out_q;
  logic signed [CRD_W-1:0] cx_out_q, cy_out_q;
  logic signed [CRD_W-1:0] cx_d, cy_d;

  function automatic logic signed [CRD_W-1:0] lerp(logic signed [CRD_W-1:0] base,
                                                   logic signed [DIF_W+PAR_W:0] p);
    logic [DIF_W+PAR_W:0] m;
    logic [DIF_W+PAR_W:0] r;
    logic signed [DIF_W+PAR_W:0] stp;
    m   = p[DIF_W+PAR_W] ? (DIF_W+PAR_W+1)'(-p) : (DIF_W+PAR_W+1)'(p);
    r   = (m + (DIF_W+PAR_W+1)'(1 << (PAR_FRAC-1))) >> PAR_FRAC;
    stp = p[DIF_W+PAR_W] ? $signed((DIF_W+PAR_W+1)'(-r)) : $signed(r);
    return CRD_W'(stp + (DIF_W+PAR_W+1)'(base));
  endfunction

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v7_q    <= 1'b0;
      v8_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i <= N_IT; i++) begin
        itv_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q     <= s_axis_tvalid;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      itv_q[0] <= v5_q;
      for (int i = 0; i < N_IT; i++) begin
        itv_q[i+1] <= itv_q[i];
      end
      v7_q    <= itv_q[N_IT];
      v8_q    <= v7_q;
      out_v_q <= v8_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_f[i] = s_axis_tdata[i*CRD_W +: CRD_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q  <= in_f[0];
      ay1_q  <= in_f[1];
      dx1_q  <= DIF_W'(in_f[2]) - DIF_W'(in_f[0]);
      dy1_q  <= DIF_W'(in_f[3]) - DIF_W'(in_f[1]);
      dx2_q  <= DIF_W'(in_f[6]) - DIF_W'(in_f[4]);
      dy2_q  <= DIF_W'(in_f[7]) - DIF_W'(in_f[5]);
      ex_q   <= DIF_W'(in_f[4]) - DIF_W'(in_f[0]);
      ey_q   <= DIF_W'(in_f[5]) - DIF_W'(in_f[1]);
      tol1_q <= tol_q;
    end
  end

  always_comb begin
    opa[0] = dx2_q; opb[0] = dy1_q;
    opa[1] = dx1_q; opb[1] = dy2_q;
    opa[2] = dx2_q; opb[2] = ey_q;
    opa[3] = ex_q;  opb[3] = dy2_q;
    opa[4] = dx1_q; opb[4] = ey_q;
    opa[5] = dy1_q; opb[5] = ex_q;
    opa[6] = dx1_q; opb[6] = dx1_q;
    opa[7] = dy1_q; opb[7] = dy1_q;
    for (int i = 0; i < N_PROD; i++) begin
      ma[i] = mag_of(opa[i]);
      mb[i] = mag_of(opb[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < N_PROD; i++) begin
        pp_q[i][0] <= ma[i][HLF_W-1:0] * mb[i][HLF_W-1:0];
        pp_q[i][1] <= ma[i][HLF_W-1:0] * mb[i][MAG_W-1:HLF_W];
        pp_q[i][2] <= ma[i][MAG_W-1:HLF_W] * mb[i][HLF_W-1:0];
        pp_q[i][3] <= ma[i][MAG_W-1:HLF_W] * mb[i][MAG_W-1:HLF_W];
        ps_q[i]    <= opa[i][DIF_W-1] ^ opb[i][DIF_W-1];
      end
      eps2_q <= tol1_q * tol1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      dx1b_q <= dx1_q;
      dy1b_q <= dy1_q;
      tol2_q <= tol1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [WIDE_W-1:0] m;
    if (en) begin
      for (int i = 0; i < N_PROD; i++) begin
        m = WIDE_W'(pp_q[i][0]) + (WIDE_W'(pp_q[i][1]) << HLF_W)
          + (WIDE_W'(pp_q[i][2]) << HLF_W) + (WIDE_W'(pp_q[i][3]) << (2*HLF_W));
        pr_q[i] <= ps_q[i] ? $signed(-m) : $signed(m);
      end
      eps3_q <= eps2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      dx1c_q <= dx1b_q;
      dy1c_q <= dy1b_q;
      tol3_q <= tol2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det4_q <= pr_q[0] - pr_q[1];
      tn4_q  <= pr_q[2] - pr_q[3];
      un4_q  <= pr_q[4] - pr_q[5];
      s4_q   <= WIDE_W'(pr_q[6]) + WIDE_W'(pr_q[7]);
      eps4_q <= eps3_q;
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
      dx1d_q <= dx1c_q;
      dy1d_q <= dy1c_q;
      tol4_q <= tol3_q;
    end
  end

  always_comb begin
    dneg5   = det4_q[WIDE_W-1];
    adet5_d = dneg5 ? DET_W'(-det4_q) : DET_W'(det4_q);
    tm5_d   = tn4_q[WIDE_W-1] ? DET_W'(-tn4_q) : DET_W'(tn4_q);
    um5_d   = un4_q[WIDE_W-1] ? DET_W'(-un4_q) : DET_W'(un4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adet5_q <= adet5_d;
      tm5_q   <= tm5_d;
      um5_q   <= um5_d;
      tneg5_q <= tn4_q[WIDE_W-1] ^ dneg5;
      uneg5_q <= un4_q[WIDE_W-1] ^ dneg5;
      tz5_q   <= (tn4_q == '0);
      uz5_q   <= (un4_q == '0);
      par5_q  <= (adet5_d == '0) || (adet5_d < DET_W'(eps4_q));
      s5_q    <= s4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;
      dx1e_q  <= dx1d_q;
      dy1e_q  <= dy1d_q;
      tol5_q  <= tol4_q;
    end
  end

  always_comb begin
    it0_d       = '0;
    it0_d.ax    = ax5_q;
    it0_d.ay    = ay5_q;
    it0_d.dx1   = dx1e_q;
    it0_d.dy1   = dy1e_q;
    it0_d.par   = par5_q;
    it0_d.tneg  = tneg5_q;
    it0_d.uneg  = uneg5_q;
    it0_d.tzero = tz5_q;
    it0_d.uzero = uz5_q;
    it0_d.tbig  = {BIG_SH'(0), tm5_q} >= {adet5_q, BIG_SH'(0)};
    it0_d.ubig  = {BIG_SH'(0), um5_q} >= {adet5_q, BIG_SH'(0)};
    it0_d.det   = adet5_q;
    it0_d.tr    = tm5_q >> BIG_SH;
    it0_d.ur    = um5_q >> BIG_SH;
    it0_d.tbits = {tm5_q[BIG_SH-1:0], (PAR_FRAC+1)'(0)};
    it0_d.ubits = {um5_q[BIG_SH-1:0], (PAR_FRAC+1)'(0)};
    it0_d.s     = s5_q;
    it0_d.mr    = ROOT_W'(tol5_q[TOL_W-1:CRD_FRAC]);
    it0_d.mbits = {tol5_q[CRD_FRAC-1:0], PAR_FRAC'(0)};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_q[0] <= it0_d;
      for (int i = 0; i < N_IT; i++) begin
        it_q[i+1] <= it_step(it_q[i], i);
      end
    end
  end

  always_comb begin
    tqf    = it_q[N_IT].tq2[DV_STEPS-1:1];
    uqf    = it_q[N_IT].uq2[DV_STEPS-1:1];
    tex    = !it_q[N_IT].tq2[0] && (it_q[N_IT].tr == '0);
    uex    = !it_q[N_IT].uq2[0] && (it_q[N_IT].ur == '0);
    lo_lim = (MQ_W+1)'(it_q[N_IT].mq);
    hi_lim = (MQ_W+1)'(1 << PAR_FRAC) + (MQ_W+1)'(it_q[N_IT].mq);
    tok = !it_q[N_IT].tbig && (it_q[N_IT].tneg ?
          ((tqf < lo_lim) || ((tqf == lo_lim) && tex)) :
          ((tqf < hi_lim) || ((tqf == hi_lim) && tex)));
    uok = !it_q[N_IT].ubig && (it_q[N_IT].uneg ?
          ((uqf < lo_lim) || ((uqf == lo_lim) && uex)) :
          ((uqf < hi_lim) || ((uqf == hi_lim) && uex)));
    if (it_q[N_IT].tneg || it_q[N_IT].tzero) begin
      tcl = '0;
    end else if (tqf >= (MQ_W+1)'(1 << PAR_FRAC)) begin
      tcl = PAR_W'(1 << PAR_FRAC);
    end else begin
      tcl = PAR_W'(tqf + (MQ_W+1)'(it_q[N_IT].tq2[0]));
    end
    if (it_q[N_IT].uneg || it_q[N_IT].uzero) begin
      ucl = '0;
    end else if (uqf >= (MQ_W+1)'(1 << PAR_FRAC)) begin
      ucl = PAR_W'(1 << PAR_FRAC);
    end else begin
      ucl = PAR_W'(uqf + (MQ_W+1)'(it_q[N_IT].uq2[0]));
    end
    if (it_q[N_IT].par) begin
      st7_d = ST_PARALLEL;
    end else if (!(tok && uok)) begin
      st7_d = ST_OUTSIDE;
    end else begin
      st7_d = ST_CROSS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st7_q <= st7_d;
      tq7_q <= (st7_d == ST_CROSS) ? tcl : '0;
      uq7_q <= (st7_d == ST_CROSS) ? ucl : '0;
      ax7_q <= it_q[N_IT].ax;
      ay7_q <= it_q[N_IT].ay;
      dx7_q <= it_q[N_IT].dx1;
      dy7_q <= it_q[N_IT].dy1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st8_q <= st7_q;
      tq8_q <= tq7_q;
      uq8_q <= uq7_q;
      ax8_q <= ax7_q;
      ay8_q <= ay7_q;
      px8_q <= dx7_q * $signed({1'b0, tq7_q});
      py8_q <= dy7_q * $signed({1'b0, tq7_q});
    end
  end

  always_comb begin
    cx_d = (st8_q == ST_CROSS) ? lerp(ax8_q, px8_q) : '0;
    cy_d = (st8_q == ST_CROSS) ? lerp(ay8_q, py8_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_out_q <= st8_q;
      tq_out_q <= tq8_q;
      uq_out_q <= uq8_q;
      cx_out_q <= cx_d;
      cy_out_q <= cy_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = st_out_q;
  assign m_axis_tdata  = {(OUT_DATA_W - 2*PAR_W - 2*CRD_W)'(0),
                          cy_out_q, cx_out_q, uq_out_q, tq_out_q};

endmodule
